// ----- design/smcr_pkg.sv -----
// Shared types and codes for the shell mark and compact-range block.
// No dependencies.
package smcr_pkg;

    typedef enum logic [2:0] {
        OP_WR_BASIS = 3'd0,
        OP_WR_ROW   = 3'd1,
        OP_WR_NBR   = 3'd2,
        OP_WR_ATOM  = 3'd3,
        OP_COMPUTE  = 3'd4,
        OP_RD_RUN   = 3'd5,
        OP_RD_SHELL = 3'd6,
        OP_NOP      = 3'd7
    } op_t;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_RANGE   = 2'd1;
    localparam logic [1:0] ST_NO_COMP = 2'd2;

    localparam logic [0:0] CFG_SHELL_COUNT = 1'd0;
    localparam logic [0:0] CFG_ATOM_COUNT  = 1'd1;

    typedef enum logic [4:0] {
        S_IDLE, S_DEC, S_CLR, S_ROW, S_ROW2, S_NB, S_NB2,
        S_AT, S_AT2, S_AS, S_AS2, S_AW, S_OFF, S_OFF2, S_RESP
    } state_t;

    typedef struct packed {
        logic take;
        logic do_write;
        logic rd_issue;
        logic clr_step;
        logic row_rd;
        logic row_load;
        logic rc_inc;
        logic nb_rd;
        logic nb_mark;
        logic at_rd;
        logic at_load;
        logic as_rd;
        logic as_acc;
        logic as_rewind;
        logic aw_write;
        logic ac_inc;
        logic off_init;
        logic off_rd;
        logic off_step;
        logic resp;
    } cmd_t;

    typedef struct packed {
        op_t  op;
        logic compute_bad;
        logic clr_last;
        logic row_done;
        logic pair_done;
        logic atom_done;
        logic scan_done;
        logic off_last;
        logic out_free;
    } sts_t;

endpackage

// ----- design/smcr_in_if.sv -----
// Input item channel: valid/ready handshake with opcode, index and value.
// No dependencies.
interface smcr_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  opcode;
    logic [13:0] index;
    logic [15:0] value;

    modport source (output valid, output opcode, output index, output value, input ready);
    modport sink (input valid, input opcode, input index, input value, output ready);
endinterface

// ----- design/smcr_out_if.sv -----
// Result item channel: valid/ready handshake with status and read-back fields.
// No dependencies.
interface smcr_out_if;
    logic               valid;
    logic               ready;
    logic [1:0]         status;
    logic [15:0]        row_size;
    logic [9:0]         run_count;
    logic [15:0]        run_low;
    logic [15:0]        run_high;
    logic [15:0]        run_offset;
    logic signed [16:0] shell_offset;

    modport source (output valid, output status, output row_size, output run_count,
                    output run_low, output run_high, output run_offset,
                    output shell_offset, input ready);
    modport sink (input valid, input status, input row_size, input run_count,
                  input run_low, input run_high, input run_offset,
                  input shell_offset, output ready);
endinterface

// ----- design/smcr_ctrl.sv -----
// Sequencer for table writes, reads and the compute passes.
// Depends on smcr_pkg.
module smcr_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  smcr_pkg::sts_t sts,
    output smcr_pkg::cmd_t cmd
);
    import smcr_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: if (in_valid) state_next = S_DEC;
            S_DEC:
            begin
                if (sts.op == OP_COMPUTE)
                    state_next = sts.compute_bad ? S_RESP : S_CLR;
                else
                    state_next = S_RESP;
            end
            S_CLR:  if (sts.clr_last) state_next = S_ROW;
            S_ROW:  state_next = sts.row_done ? S_AT : S_ROW2;
            S_ROW2: state_next = S_NB;
            S_NB:   state_next = sts.pair_done ? S_ROW : S_NB2;
            S_NB2:  state_next = S_NB;
            S_AT:   state_next = sts.atom_done ? S_OFF : S_AT2;
            S_AT2:  state_next = S_AS;
            S_AS:   state_next = sts.scan_done ? S_AW : S_AS2;
            S_AS2:  state_next = S_AS;
            S_AW:   if (sts.scan_done) state_next = S_AT;
            S_OFF:  state_next = S_OFF2;
            S_OFF2: state_next = sts.off_last ? S_RESP : S_OFF;
            S_RESP: if (sts.out_free) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                cmd.take = in_valid;
            end
            S_DEC:
            begin
                cmd.do_write = 1'b1;
                cmd.rd_issue = 1'b1;
            end
            S_CLR:  cmd.clr_step = 1'b1;
            S_ROW:  cmd.row_rd = !sts.row_done;
            S_ROW2: cmd.row_load = 1'b1;
            S_NB:
            begin
                cmd.rc_inc = sts.pair_done;
                cmd.nb_rd  = !sts.pair_done;
            end
            S_NB2:  cmd.nb_mark = 1'b1;
            S_AT:
            begin
                cmd.off_init = sts.atom_done;
                cmd.at_rd    = !sts.atom_done;
            end
            S_AT2:  cmd.at_load = 1'b1;
            S_AS:
            begin
                cmd.as_rewind = sts.scan_done;
                cmd.as_rd     = !sts.scan_done;
            end
            S_AS2:  cmd.as_acc = 1'b1;
            S_AW:
            begin
                cmd.ac_inc   = sts.scan_done;
                cmd.aw_write = !sts.scan_done;
            end
            S_OFF:  cmd.off_rd = 1'b1;
            S_OFF2: cmd.off_step = 1'b1;
            S_RESP: cmd.resp = sts.out_free;
            default: cmd = '0;
        endcase
    end

endmodule

// ----- design/smcr_dp.sv -----
// Datapath: tables, mark and offset memories, counters and result register.
// Depends on smcr_pkg and smcr_out_if.
module smcr_dp #(
    parameter int MAX_SHELLS = 1024,
    parameter int MAX_ATOMS  = 256,
    parameter int MAX_PAIRS  = 16384,
    parameter int MAX_RUNS   = 512
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cfg_we,
    input  logic [0:0]     cfg_index,
    input  logic [10:0]    cfg_data,
    input  logic [2:0]     in_opcode,
    input  logic [13:0]    in_index,
    input  logic [15:0]    in_value,
    input  smcr_pkg::cmd_t cmd,
    output smcr_pkg::sts_t sts,
    smcr_out_if.source     out_ch
);
    import smcr_pkg::*;

    localparam int SAW = $clog2(MAX_SHELLS + 1);
    localparam int POW = $clog2(MAX_SHELLS);
    localparam int NAW = $clog2(MAX_ATOMS + 1);
    localparam int PAW = (MAX_PAIRS > 1) ? $clog2(MAX_PAIRS) : 1;
    localparam int CW  = (PAW + 1 > 17) ? PAW + 1 : 17;
    localparam int RAW = (MAX_RUNS > 1) ? $clog2(MAX_RUNS) : 1;
    localparam int RCW = $clog2(MAX_RUNS + 1);

    logic [15:0] basis_mem [MAX_SHELLS + 1];
    logic [15:0] row_mem   [MAX_SHELLS + 1];
    logic [15:0] nbr_mem   [MAX_PAIRS];
    logic [15:0] atom_mem  [MAX_ATOMS + 1];
    logic        mark_mem  [MAX_SHELLS];
    logic [16:0] po_mem    [MAX_SHELLS];
    logic [47:0] run_mem   [MAX_RUNS];

    logic [10:0]    shell_count_reg;
    logic [8:0]     atom_count_reg;
    op_t            op_reg;
    logic [13:0]    idx_reg;
    logic [15:0]    val_reg;
    logic [15:0]    rc_reg;
    logic [CW-1:0]  pc_reg;
    logic [CW-1:0]  pend_reg;
    logic [NAW-1:0] ac_reg;
    logic [15:0]    pos_reg;
    logic [15:0]    as_reg;
    logic [15:0]    ae_reg;
    logic           any_reg;
    logic [15:0]    total_reg;
    logic [RCW-1:0] runs_reg;
    logic           computed_reg;
    logic           in_run_reg;
    logic [15:0]    run_lo_reg;
    logic [15:0]    run_off_reg;
    logic           out_valid_reg;

    logic [15:0] row_q0, row_q1, nb_q, at_q0, at_q1, b_q0, b_q1;
    logic        mark_q;
    logic [16:0] po_q;
    logic [47:0] run_q;

    logic [SAW-1:0] ns;
    logic [NAW-1:0] na;
    logic [15:0]    pos1;
    logic           m;
    logic [15:0]    sz;
    logic [16:0]    sum;
    logic [1:0]     res_status;
    logic           wr_ok;
    logic           nb_ok;

    assign ns = (shell_count_reg > MAX_SHELLS) ? SAW'(MAX_SHELLS) : SAW'(shell_count_reg);
    assign na = (atom_count_reg > MAX_ATOMS) ? NAW'(MAX_ATOMS) : NAW'(atom_count_reg);
    assign pos1 = (pos_reg == 16'(MAX_SHELLS)) ? pos_reg : pos_reg + 16'd1;
    assign m = (pos_reg < 16'(ns)) && mark_q;
    assign sz = (b_q1 > b_q0) ? b_q1 - b_q0 : 16'd0;
    assign sum = {1'b0, total_reg} + {1'b0, sz};
    assign nb_ok = nb_q < 16'(ns);

    always_comb
    begin
        case (op_reg)
            OP_WR_BASIS, OP_WR_ROW: wr_ok = idx_reg <= 14'(ns);
            OP_WR_NBR:              wr_ok = 32'(idx_reg) < MAX_PAIRS;
            OP_WR_ATOM:             wr_ok = 32'(idx_reg) <= 32'(na);
            default:                wr_ok = 1'b1;
        endcase
    end

    always_comb
    begin
        case (op_reg)
            OP_WR_BASIS, OP_WR_ROW, OP_WR_NBR, OP_WR_ATOM:
                res_status = wr_ok ? ST_OK : ST_RANGE;
            OP_COMPUTE:
                res_status = (val_reg >= 16'(ns)) ? ST_RANGE : ST_OK;
            OP_RD_RUN:
                res_status = !computed_reg ? ST_NO_COMP :
                             (32'(idx_reg) >= 32'(runs_reg)) ? ST_RANGE : ST_OK;
            OP_RD_SHELL:
                res_status = !computed_reg ? ST_NO_COMP :
                             (idx_reg >= 14'(ns)) ? ST_RANGE : ST_OK;
            default:
                res_status = ST_OK;
        endcase
    end

    always_comb
    begin
        sts.op          = op_reg;
        sts.compute_bad = val_reg >= 16'(ns);
        sts.clr_last    = pos_reg == 16'(MAX_SHELLS - 1);
        sts.row_done    = rc_reg > val_reg;
        sts.pair_done   = pc_reg >= pend_reg;
        sts.atom_done   = ac_reg >= na;
        sts.scan_done   = pos_reg >= ae_reg;
        sts.off_last    = pos_reg == 16'(MAX_SHELLS);
        sts.out_free    = !out_valid_reg || out_ch.ready;
    end

    // configuration and control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shell_count_reg <= 11'd1;
            atom_count_reg  <= 9'd1;
            total_reg       <= '0;
            runs_reg        <= '0;
            computed_reg    <= 1'b0;
            in_run_reg      <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we && cfg_index == CFG_SHELL_COUNT)
                shell_count_reg <= cfg_data;
            if (cfg_we && cfg_index == CFG_ATOM_COUNT)
                atom_count_reg <= cfg_data[8:0];
            if (cmd.off_init)
            begin
                total_reg  <= '0;
                runs_reg   <= '0;
                in_run_reg <= 1'b0;
            end
            if (cmd.off_step)
            begin
                if (m)
                    total_reg <= sum[16] ? 16'hFFFF : sum[15:0];
                if (!m && in_run_reg && runs_reg < RCW'(MAX_RUNS))
                    runs_reg <= runs_reg + RCW'(1);
                in_run_reg <= m;
                if (sts.off_last)
                    computed_reg <= 1'b1;
            end
            if (cmd.resp)
                out_valid_reg <= 1'b1;
            else if (out_ch.ready)
                out_valid_reg <= 1'b0;
        end
    end

    // counters and working registers
    always_ff @(posedge clk)
    begin
        if (cmd.take)
        begin
            op_reg  <= op_t'(in_opcode);
            idx_reg <= in_index;
            val_reg <= in_value;
            rc_reg  <= 16'(in_index);
            pos_reg <= '0;
            ac_reg  <= '0;
        end
        if (cmd.clr_step || cmd.as_acc || cmd.aw_write)
            pos_reg <= pos_reg + 16'd1;
        if (cmd.rc_inc)
            rc_reg <= rc_reg + 16'd1;
        if (cmd.row_load)
        begin
            pc_reg   <= CW'(row_q0);
            pend_reg <= (CW'(row_q1) > CW'(MAX_PAIRS)) ? CW'(MAX_PAIRS) : CW'(row_q1);
        end
        if (cmd.nb_rd)
            pc_reg <= pc_reg + CW'(1);
        if (cmd.at_load)
        begin
            as_reg  <= at_q0;
            ae_reg  <= (at_q1 > 16'(ns)) ? 16'(ns) : at_q1;
            pos_reg <= at_q0;
            any_reg <= 1'b0;
        end
        if (cmd.as_acc)
            any_reg <= any_reg | mark_q;
        if (cmd.as_rewind)
            pos_reg <= as_reg;
        if (cmd.ac_inc)
            ac_reg <= ac_reg + NAW'(1);
        if (cmd.off_init)
            pos_reg <= '0;
        if (cmd.off_step)
        begin
            if (!sts.off_last)
                pos_reg <= pos_reg + 16'd1;
            if (m && !in_run_reg)
            begin
                run_lo_reg  <= b_q0;
                run_off_reg <= total_reg;
            end
        end
    end

    // table memories
    always_ff @(posedge clk)
    begin
        if (cmd.do_write && wr_ok && op_reg == OP_WR_BASIS)
            basis_mem[SAW'(idx_reg)] <= val_reg;
        if (cmd.off_rd)
        begin
            b_q0 <= basis_mem[SAW'(pos_reg)];
            b_q1 <= basis_mem[SAW'(pos1)];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.do_write && wr_ok && op_reg == OP_WR_ROW)
            row_mem[SAW'(idx_reg)] <= val_reg;
        if (cmd.row_rd)
        begin
            row_q0 <= row_mem[SAW'(rc_reg)];
            row_q1 <= row_mem[SAW'(rc_reg + 16'd1)];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.do_write && wr_ok && op_reg == OP_WR_NBR)
            nbr_mem[PAW'(idx_reg)] <= val_reg;
        if (cmd.nb_rd)
            nb_q <= nbr_mem[PAW'(pc_reg)];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.do_write && wr_ok && op_reg == OP_WR_ATOM)
            atom_mem[NAW'(idx_reg)] <= val_reg;
        if (cmd.at_rd)
        begin
            at_q0 <= atom_mem[ac_reg];
            at_q1 <= atom_mem[ac_reg + NAW'(1)];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.clr_step)
            mark_mem[POW'(pos_reg)] <= 1'b0;
        else if (cmd.nb_mark && nb_ok)
            mark_mem[POW'(nb_q)] <= 1'b1;
        else if (cmd.aw_write)
            mark_mem[POW'(pos_reg)] <= any_reg;
        if (cmd.as_rd || cmd.off_rd)
            mark_q <= mark_mem[POW'(pos_reg)];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.off_step && pos_reg < 16'(MAX_SHELLS))
            po_mem[POW'(pos_reg)] <= m ? {1'b0, total_reg} : '1;
        if (cmd.rd_issue)
            po_q <= po_mem[POW'(idx_reg)];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.off_step && !m && in_run_reg && runs_reg < RCW'(MAX_RUNS))
            run_mem[RAW'(runs_reg)] <= {run_lo_reg, b_q0 - 16'd1, run_off_reg};
        if (cmd.rd_issue)
            run_q <= run_mem[RAW'(idx_reg)];
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (cmd.resp)
        begin
            out_ch.status     <= res_status;
            out_ch.row_size   <= total_reg;
            out_ch.run_count  <= 10'(runs_reg);
            out_ch.run_low    <= '0;
            out_ch.run_high   <= '0;
            out_ch.run_offset <= '0;
            out_ch.shell_offset <= '0;
            if (op_reg == OP_RD_RUN && res_status == ST_OK)
            begin
                out_ch.run_low    <= run_q[47:32];
                out_ch.run_high   <= run_q[31:16];
                out_ch.run_offset <= run_q[15:0];
            end
            if (op_reg == OP_RD_SHELL && res_status == ST_OK)
                out_ch.shell_offset <= signed'(po_q);
        end
    end

    assign out_ch.valid = out_valid_reg;

endmodule

// ----- design/shell_mark_compact_ranges.sv -----
// Top level of the shell mark and compact-range block.
// Depends on smcr_pkg, smcr_in_if, smcr_out_if, smcr_ctrl and smcr_dp.
//
// Items arrive on in_ch (opcode, index, value); one result item per input
// item leaves on out_ch. Configuration registers (shell count, atom count)
// are written through cfg_we/cfg_index/cfg_data; the user must write them only
// while the block is idle, which the block does not enforce. Table writes,
// reads and a no-op pass through decode and the result state. A compute item
// runs a fixed sequence of passes: a clear pass over all MAX_SHELLS marks, a
// row pass marking each neighbour shell listed for rows index to value, an
// atom pass ORing the marks over each atom's shells and writing them back, and
// an offset and run pass. One item is worked on at a time.
// Reset returns the counts to one and clears the totals, run count and
// computed flag; tables hold no value until written.
// A finished result waits in the output register while out_ch.ready is low;
// the next item is taken meanwhile and its result holds until that clears.
module shell_mark_compact_ranges #(
    parameter int MAX_SHELLS = 1024,
    parameter int MAX_ATOMS  = 256,
    parameter int MAX_PAIRS  = 16384,
    parameter int MAX_RUNS   = 512
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [0:0]  cfg_index,
    input  logic [10:0] cfg_data,
    smcr_in_if.sink     in_ch,
    smcr_out_if.source  out_ch
);
    import smcr_pkg::*;

    cmd_t cmd;
    sts_t sts;

    smcr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_ready (in_ch.ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    smcr_dp #(
        .MAX_SHELLS (MAX_SHELLS),
        .MAX_ATOMS  (MAX_ATOMS),
        .MAX_PAIRS  (MAX_PAIRS),
        .MAX_RUNS   (MAX_RUNS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_opcode (in_ch.opcode),
        .in_index  (in_ch.index),
        .in_value  (in_ch.value),
        .cmd       (cmd),
        .sts       (sts),
        .out_ch    (out_ch)
    );

endmodule
